// ===== hw/rtl/tss_pkg.sv =====
// Shared types and constants for the timed step sequencer.
// Used by tss_step_store and timed_step_sequencer; no dependencies.
package tss_pkg;

   localparam int MAX_STEPS     = 64;
   localparam int IDX_BITS      = $clog2(MAX_STEPS);
   localparam int CNT_BITS      = $clog2(MAX_STEPS + 1);
   localparam int ACTION_BITS   = 4;
   localparam int DUR_BITS      = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOP_ENABLE = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDLE_ACTION = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_APPEND = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } seq_state_type;

   typedef logic [IDX_BITS-1:0]    step_idx_type;
   typedef logic [CNT_BITS-1:0]    step_cnt_type;
   typedef logic [ACTION_BITS-1:0] action_type;
   typedef logic [DUR_BITS-1:0]    duration_type;

   typedef struct packed {
      opcode_type   opcode;
      action_type   step_action;
      duration_type step_duration;
   } req_item_type;

   typedef struct packed {
      action_type action;
      logic       stopped;
      logic       append_rejected;
   } rsp_item_type;

   typedef struct packed {
      action_type   action;
      duration_type duration;
   } step_type;

   // Access group from the sequencer control to the step store
   typedef struct packed {
      logic         wr_en;
      step_idx_type wr_addr;
      step_type     wr_step;
      logic         rd_en;
      step_idx_type rd_addr;
   } store_req_type;

endpackage

// ===== hw/rtl/tss_step_store.sv =====
// Step store: one write port, one read port, registered read data.
// Depends on tss_pkg.
module tss_step_store import tss_pkg::*; (
   input  logic          clock,
   input  store_req_type store_req,
   output step_type      rd_step
);

   step_type mem [MAX_STEPS];
   step_type rd_step_ff;

   // Write on request; register read data, hold it between reads
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_step;
      end
      if (store_req.rd_en) begin
         rd_step_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_step = rd_step_ff;

endmodule

// ===== hw/rtl/timed_step_sequencer.sv =====
// Top level of the timed step sequencer: control state, config registers,
// result register. Depends on tss_pkg and tss_step_store.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_item (opcode, step_action, step_duration)
//   rsp_      out        rsp_valid/rsp_stall  rsp_item (action, stopped, append_rejected)
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Each item is accepted in S_IDLE, which reads the next step from the store;
// S_EXEC then applies the update and loads the result register.
// No new item is taken until the update of the last one is done.
// Reset is synchronous and leaves the list empty; the store needs no clearing.
// A held result does not block the next transfer in, but the update of that
// item waits until the result register is free.
module timed_step_sequencer import tss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   seq_state_type state_ff, state_in;
   req_item_type  item_ff, item_in;
   step_cnt_type  step_total_ff, step_total_in;
   step_idx_type  position_ff, position_in;
   duration_type  remaining_ff, remaining_in;
   action_type    current_action_ff, current_action_in;
   logic          finished_ff, finished_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic          loop_enable_ff;
   action_type    idle_action_ff;

   store_req_type store_req;
   step_type      rd_step;
   logic          rsp_free;
   logic          adv_ok;
   step_idx_type  next_idx;
   logic          stop_now;

   tss_step_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_step   (rd_step)
   );

   // Configuration writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enable_ff <= 1'b0;
         idle_action_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOOP_ENABLE: loop_enable_ff <= csr_wdata[0];
            CSR_IDLE_ACTION: idle_action_ff <= action_type'(csr_wdata);
            default:         loop_enable_ff <= loop_enable_ff;
         endcase
      end
   end

   // Next step index: advance inside the list, otherwise wrap to the first
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign adv_ok   = (step_cnt_type'(position_ff) + step_cnt_type'(1)) < step_total_ff;
   assign next_idx = adv_ok ? (position_ff + step_idx_type'(1)) : '0;

   // State register and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         step_total_ff     <= '0;
         position_ff       <= '0;
         remaining_ff      <= '0;
         current_action_ff <= '0;
         finished_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         step_total_ff     <= step_total_in;
         position_ff       <= position_in;
         remaining_ff      <= remaining_in;
         current_action_ff <= current_action_in;
         finished_ff       <= finished_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Next state, store access and the per-item update
   always_comb begin
      state_in          = state_ff;
      item_in           = item_ff;
      step_total_in     = step_total_ff;
      position_in       = position_ff;
      remaining_in      = remaining_ff;
      current_action_in = current_action_ff;
      finished_in       = finished_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_item_in       = rsp_item_ff;
      store_req         = '0;
      req_stall         = 1'b1;
      stop_now          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            // Latch the transfer and fetch the step a tick may need
            if (req_valid) begin
               item_in           = req_item;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = next_idx;
               state_in          = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               rsp_item_in.append_rejected = 1'b0;
               unique case (item_ff.opcode)
                  OP_TICK: begin
                     if ((step_total_ff != '0) && !finished_ff) begin
                        // Replace a spent step: advance, wrap or stop
                        if (remaining_ff == '0) begin
                           if (adv_ok || loop_enable_ff) begin
                              position_in       = next_idx;
                              current_action_in = rd_step.action;
                              remaining_in      = rd_step.duration;
                           end else begin
                              finished_in = 1'b1;
                           end
                        end
                        if (!finished_in && (remaining_in != '0)) begin
                           remaining_in = remaining_in - duration_type'(1);
                        end
                     end
                  end
                  OP_APPEND: begin
                     if (step_total_ff == step_cnt_type'(MAX_STEPS)) begin
                        rsp_item_in.append_rejected = 1'b1;
                     end else begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = step_idx_type'(step_total_ff);
                        store_req.wr_step = '{action:   item_ff.step_action,
                                              duration: item_ff.step_duration};
                        // First step of an empty list becomes current at once
                        if (step_total_ff == '0) begin
                           position_in       = '0;
                           current_action_in = item_ff.step_action;
                           remaining_in      = item_ff.step_duration;
                        end
                        step_total_in = step_total_ff + step_cnt_type'(1);
                     end
                  end
                  OP_CLEAR: begin
                     step_total_in = '0;
                     position_in   = '0;
                     remaining_in  = '0;
                     finished_in   = 1'b0;
                  end
                  OP_NOP: begin
                     step_total_in = step_total_ff;
                  end
               endcase
               // Report the updated state
               stop_now            = finished_in || (step_total_in == '0);
               rsp_item_in.action  = stop_now ? idle_action_ff : current_action_in;
               rsp_item_in.stopped = stop_now;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Position stays inside a non-empty list
   a_pos_in_list: assert property (@(posedge clock) disable iff (reset)
      (step_total_ff != '0) |-> (step_cnt_type'(position_ff) < step_total_ff))
      else $error("position outside the stored list");

   // Step count never exceeds the store depth
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      step_total_ff <= step_cnt_type'(MAX_STEPS))
      else $error("step count beyond store depth");

   // An empty list holds no remaining count
   a_empty_rem: assert property (@(posedge clock) disable iff (reset)
      (step_total_ff == '0) |-> (remaining_ff == '0))
      else $error("remaining count on an empty list");

   // A blocked result register holds the update back
   a_exec_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_valid_ff && rsp_stall) |=>
      (state_ff == S_EXEC && $stable(rsp_item_ff)))
      else $error("update overran a held result");

   // Every completed update presents a result
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("update finished without a result");

endmodule
